// ===== rtl/core/pte_pkg.sv =====
// Shared types, constants and coefficient tables for the Pade sine/cosine/tangent evaluator.
// Depends on nothing; every module of the block takes names from here by scope.
package pte_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS      = 28;
   localparam int POLY_SHIFT     = 20;
   localparam int NUM_COEFS      = 5;
   localparam int HORNER_STEPS   = NUM_COEFS - 1;
   localparam int MAC_STEPS      = HORNER_STEPS + 1;
   localparam int ANGLE_W        = 32;
   localparam int VALUE_W        = 32;
   localparam int Y_W            = 35;
   localparam int MAG_W          = 62;

   localparam logic [1:0] KIND_SIN = 2'd0;
   localparam logic [1:0] KIND_COS = 2'd1;
   localparam logic [1:0] KIND_TAN = 2'd2;

   localparam logic [Y_W-1:0] ONE_Q28 = Y_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic [1:0]         kind;
      logic [Y_W-1:0]     y;
      logic               x_neg;
      logic [ANGLE_W-1:0] x_mag;
   } side_type;

   // Sine and cosine carry a leading zero so every kind runs the same number of steps.
   localparam logic signed [63:0] NUM_TBL [3][5] = '{
      '{64'sd0, -64'sd479249, 64'sd52785432, -64'sd1640635920, 64'sd11511339840},
      '{64'sd0, -64'sd14615, 64'sd1075032, -64'sd18471600, 64'sd39251520},
      '{64'sd1, -64'sd990, 64'sd135135, -64'sd4729725, 64'sd34459425}};
   localparam logic signed [63:0] DEN_TBL [3][5] = '{
      '{64'sd0, 64'sd18361, 64'sd3177720, 64'sd277920720, 64'sd11511339840},
      '{64'sd0, 64'sd127, 64'sd16632, 64'sd1154160, 64'sd39251520},
      '{64'sd45, -64'sd13860, 64'sd945945, -64'sd16216200, 64'sd34459425}};

   // Coefficient scaled to Q.20; zero for the unused selector.
   function automatic logic signed [63:0] coef(input logic [1:0] kind, input logic [2:0] idx,
                                               input logic den);
      logic signed [63:0] c;
      c = '0;
      if (kind <= KIND_TAN && idx < 3'(NUM_COEFS)) begin
         c = den ? DEN_TBL[kind][idx] : NUM_TBL[kind][idx];
      end
      return c <<< POLY_SHIFT;
   endfunction

endpackage

// ===== rtl/core/pte_front.sv =====
// Front end: registers the angle, takes its magnitude, squares it to Q7.28 and
// loads the leading polynomial coefficients. Depends on pte_pkg.
module pte_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [1:0]                   in_kind,
   input  logic [pte_pkg::ANGLE_W-1:0]  in_angle,
   output logic                         out_valid,
   output pte_pkg::side_type            out_side,
   output logic signed [63:0]           out_num,
   output logic signed [63:0]           out_den
);

   logic                        v1_ff, v2_ff, v3_ff;
   logic [1:0]                  kind1_ff, kind2_ff;
   logic [pte_pkg::ANGLE_W-1:0] angle1_ff;
   logic                        neg2_ff;
   logic [pte_pkg::ANGLE_W-1:0] mag2_ff, mag2_in;
   pte_pkg::side_type           side3_ff, side3_in;
   logic signed [63:0]          num3_ff, den3_ff;
   logic [63:0]                 sq;

   always_comb begin
      mag2_in = angle1_ff[pte_pkg::ANGLE_W-1] ? (~angle1_ff + 1'b1) : angle1_ff;
      sq = 64'(mag2_ff) * 64'(mag2_ff);
      side3_in.kind  = kind2_ff;
      side3_in.y     = sq[pte_pkg::FRAC_BITS +: pte_pkg::Y_W];
      side3_in.x_neg = neg2_ff;
      side3_in.x_mag = mag2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind1_ff  <= in_kind;
         angle1_ff <= in_angle;
         kind2_ff  <= kind1_ff;
         neg2_ff   <= angle1_ff[pte_pkg::ANGLE_W-1];
         mag2_ff   <= mag2_in;
         side3_ff  <= side3_in;
         num3_ff   <= pte_pkg::coef(kind2_ff, 3'd0, 1'b0);
         den3_ff   <= pte_pkg::coef(kind2_ff, 3'd0, 1'b1);
      end
   end

   assign out_valid = v3_ff;
   assign out_side  = side3_ff;
   assign out_num   = num3_ff;
   assign out_den   = den3_ff;

endmodule

// ===== rtl/core/pte_mac.sv =====
// One Horner step for numerator and denominator lanes: trunc(v * m / 2^28) + addend,
// split into four 31x18/31x17 partial products over four stages. Depends on pte_pkg.
module pte_mac (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  pte_pkg::side_type          in_side,
   input  logic signed [63:0]         num_v,
   input  logic signed [63:0]         den_v,
   input  logic [pte_pkg::Y_W-1:0]    num_m,
   input  logic                       num_mneg,
   input  logic [pte_pkg::Y_W-1:0]    den_m,
   input  logic                       den_mneg,
   input  logic signed [63:0]         num_add,
   input  logic signed [63:0]         den_add,
   output logic                       out_valid,
   output pte_pkg::side_type          out_side,
   output logic signed [63:0]         num_r,
   output logic signed [63:0]         den_r
);

   logic               valid_ff [4];
   pte_pkg::side_type  side_ff [4];

   logic signed [63:0]          v_w [2];
   logic [pte_pkg::Y_W-1:0]     m_w [2];
   logic                        mneg_w [2];
   logic signed [63:0]          add_w [2];
   logic signed [63:0]          res_w [2];

   assign v_w[0]    = num_v;
   assign v_w[1]    = den_v;
   assign m_w[0]    = num_m;
   assign m_w[1]    = den_m;
   assign mneg_w[0] = num_mneg;
   assign mneg_w[1] = den_mneg;
   assign add_w[0]  = num_add;
   assign add_w[1]  = den_add;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < 4; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < 4; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic [pte_pkg::MAG_W-1:0]   mag1_ff, mag1_in;
      logic [pte_pkg::Y_W-1:0]     m1_ff;
      logic                        neg1_ff, neg2_ff, neg3_ff, neg_in;
      logic signed [63:0]          add1_ff, add2_ff, add3_ff;
      logic [48:0]                 pp_ff [4];
      logic [48:0]                 pp_in [4];
      logic [66:0]                 a3_ff, b3_ff, a3_in, b3_in;
      logic [97:0]                 prod;
      logic signed [63:0]          mag_s;
      logic signed [63:0]          r4_ff, r4_in;

      always_comb begin
         mag1_in  = pte_pkg::MAG_W'(v_w[ln][63] ? -v_w[ln] : v_w[ln]);
         neg_in   = v_w[ln][63] ^ mneg_w[ln];
         pp_in[0] = 49'(mag1_ff[30:0]) * 49'(m1_ff[17:0]);
         pp_in[1] = 49'(mag1_ff[30:0]) * 49'(m1_ff[34:18]);
         pp_in[2] = 49'(mag1_ff[61:31]) * 49'(m1_ff[17:0]);
         pp_in[3] = 49'(mag1_ff[61:31]) * 49'(m1_ff[34:18]);
         a3_in    = 67'(pp_ff[0]) + (67'(pp_ff[1]) << 18);
         b3_in    = 67'(pp_ff[2]) + (67'(pp_ff[3]) << 18);
         prod     = 98'(a3_ff) + (98'(b3_ff) << 31);
         mag_s    = signed'({2'b00, prod[pte_pkg::FRAC_BITS +: pte_pkg::MAG_W]});
         r4_in    = (neg3_ff ? -mag_s : mag_s) + add3_ff;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            mag1_ff <= mag1_in;
            m1_ff   <= m_w[ln];
            neg1_ff <= neg_in;
            add1_ff <= add_w[ln];
            for (int i = 0; i < 4; i++) pp_ff[i] <= pp_in[i];
            neg2_ff <= neg1_ff;
            add2_ff <= add1_ff;
            a3_ff   <= a3_in;
            b3_ff   <= b3_in;
            neg3_ff <= neg2_ff;
            add3_ff <= add2_ff;
            r4_ff   <= r4_in;
         end
      end

      assign res_w[ln] = r4_ff;
   end

   assign out_valid = valid_ff[3];
   assign out_side  = side_ff[3];
   assign num_r     = res_w[0];
   assign den_r     = res_w[1];

endmodule

// ===== rtl/core/pte_div.sv =====
// Restoring divider, one quotient bit per stage, with saturation to the signed
// DATA_WIDTH range and the final Q4.28 result. Depends on pte_pkg.
module pte_div #(
   parameter int DATA_WIDTH = pte_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [1:0]                   in_kind,
   input  logic signed [63:0]           in_num,
   input  logic signed [63:0]           in_den,
   output logic                         out_valid,
   output logic [pte_pkg::VALUE_W-1:0]  out_value,
   output logic                         out_sat
);

   localparam int QW = DATA_WIDTH + 5;
   localparam int VW = (QW + 1 > pte_pkg::VALUE_W) ? QW + 1 : pte_pkg::VALUE_W;
   localparam int EW = 64 + pte_pkg::FRAC_BITS;
   localparam logic [QW-1:0] LIM_Q = QW'(1) << (DATA_WIDTH - 1);
   localparam logic signed [VW-1:0] LIM_V = VW'(1) << (DATA_WIDTH - 1);

   // Prepare stage: magnitudes and signs.
   logic        v0_ff, neg0_ff, unused0_ff;
   logic [63:0] un0_ff, ud0_ff;

   // Step pipeline, index 0 is the stage after the range check.
   logic          vld_ff    [QW+1];
   logic          neg_ff    [QW+1];
   logic          unused_ff [QW+1];
   logic          ovf_ff    [QW+1];
   logic [63:0]   ud_ff     [QW+1];
   logic [63:0]   r_ff      [QW+1];
   logic [QW-1:0] dq_ff     [QW+1];

   logic [EW-1:0] ext;
   logic [EW-1:0] hi;
   logic          ovf_in;

   logic                      vf_ff, satf_ff;
   logic [pte_pkg::VALUE_W-1:0] valf_ff, valf_in;
   logic                      satf_in, sat_w;
   logic [QW-1:0]             q_w;
   logic signed [VW-1:0]      val_w;

   always_ff @(posedge clock) begin
      if (en) begin
         un0_ff     <= in_num[63] ? 64'(-in_num) : 64'(in_num);
         ud0_ff     <= in_den[63] ? 64'(-in_den) : 64'(in_den);
         neg0_ff    <= in_num[63] ^ in_den[63];
         unused0_ff <= in_kind > pte_pkg::KIND_TAN;
      end
   end

   // A zero denominator always fails the range check.
   always_comb begin
      ext    = {un0_ff, {pte_pkg::FRAC_BITS{1'b0}}};
      hi     = ext >> QW;
      ovf_in = hi >= EW'(ud0_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff     <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         v0_ff     <= in_valid;
         vld_ff[0] <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0]    <= neg0_ff;
         unused_ff[0] <= unused0_ff;
         ovf_ff[0]    <= ovf_in;
         ud_ff[0]     <= ud0_ff;
         r_ff[0]      <= hi[63:0];
         dq_ff[0]     <= ext[QW-1:0];
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [63:0]   rs, r_in;
      logic          ge;
      logic [QW-1:0] dq_in;

      always_comb begin
         rs    = {r_ff[k][62:0], dq_ff[k][QW-1]};
         ge    = rs >= ud_ff[k];
         r_in  = ge ? rs - ud_ff[k] : rs;
         dq_in = {dq_ff[k][QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[k+1]    <= neg_ff[k];
            unused_ff[k+1] <= unused_ff[k];
            ovf_ff[k+1]    <= ovf_ff[k];
            ud_ff[k+1]     <= ud_ff[k];
            r_ff[k+1]      <= r_in;
            dq_ff[k+1]     <= dq_in;
         end
      end
   end

   always_comb begin
      q_w   = dq_ff[QW];
      sat_w = ovf_ff[QW] | (neg_ff[QW] ? (q_w > LIM_Q) : (q_w > LIM_Q - 1'b1));
      if (sat_w) begin
         val_w = neg_ff[QW] ? -LIM_V : LIM_V - 1'b1;
      end else begin
         val_w = neg_ff[QW] ? -signed'(VW'(q_w)) : signed'(VW'(q_w));
      end
      valf_in = unused_ff[QW] ? '0 : val_w[pte_pkg::VALUE_W-1:0];
      satf_in = unused_ff[QW] ? 1'b0 : sat_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else if (en) begin
         vf_ff <= vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         valf_ff <= valf_in;
         satf_ff <= satf_in;
      end
   end

   assign out_valid = vf_ff;
   assign out_value = valf_ff;
   assign out_sat   = satf_ff;

endmodule

// ===== rtl/core/pade_trig_evaluator.sv =====
// Top level of the Pade sine/cosine/tangent evaluator: front end, five MAC steps,
// divider and the output register with skid stage. Depends on pte_pkg and all pte_ modules.
//
// Usage:
//   Input beats arrive on req_: req_tdata is the Q4.28 angle, req_tuser the
//   function selector (0 sine, 1 cosine, 2 tangent; 3 gives zero, no flag).
//   Result beats leave on rsp_: rsp_tdata is the Q4.28 value, rsp_tuser the
//   saturation flag, set when the quotient left the signed DATA_WIDTH range
//   or the denominator was zero.
//   The path from the accepting edge to rsp_tvalid runs through DATA_WIDTH + 32
//   register stages, the first loaded on the accepting edge: three front-end
//   stages, four in each of five multiply-add steps, a divider that retires one
//   quotient bit per stage over DATA_WIDTH + 5 stages plus three around it, and
//   the output register.
//   Throughput is one beat per cycle while the skid stage is empty; no state is kept between beats.
//   When the receiver stalls, the waiting result sits in the output register,
//   one more lands in the skid stage, and then req_tready drops and the whole
//   pipeline holds until rsp_tready returns.
//   Synchronous reset empties the pipeline; req_tready is high after reset.
module pade_trig_evaluator #(
   parameter int DATA_WIDTH = pte_pkg::DATA_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] angle
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [0:0]  rsp_tuser    // [0] saturated
);

   localparam int NS = pte_pkg::MAC_STEPS;

   logic en;

   logic               st_valid [NS+1];
   pte_pkg::side_type  st_side  [NS+1];
   logic signed [63:0] st_num   [NS+1];
   logic signed [63:0] st_den   [NS+1];

   logic                        d_valid, d_sat;
   logic [pte_pkg::VALUE_W-1:0] d_value;

   logic        out_valid_ff, out_sat_ff, skid_full_ff, skid_sat_ff;
   logic [31:0] out_value_ff, skid_value_ff;

   assign en = !skid_full_ff;

   pte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_kind   (req_tuser),
      .in_angle  (req_tdata),
      .out_valid (st_valid[0]),
      .out_side  (st_side[0]),
      .out_num   (st_num[0]),
      .out_den   (st_den[0])
   );

   for (genvar s = 0; s < NS; s++) begin : g_mac
      logic [pte_pkg::Y_W-1:0] num_m, den_m;
      logic                    num_mneg;
      logic signed [63:0]      num_add, den_add;

      // Horner steps multiply by y; the last step applies x to sine and tangent.
      always_comb begin
         if (s < pte_pkg::HORNER_STEPS) begin
            num_m    = st_side[s].y;
            num_mneg = 1'b0;
            den_m    = st_side[s].y;
            num_add  = pte_pkg::coef(st_side[s].kind, 3'(s + 1), 1'b0);
            den_add  = pte_pkg::coef(st_side[s].kind, 3'(s + 1), 1'b1);
         end else begin
            if (st_side[s].kind == pte_pkg::KIND_COS) begin
               num_m    = pte_pkg::ONE_Q28;
               num_mneg = 1'b0;
            end else begin
               num_m    = pte_pkg::Y_W'(st_side[s].x_mag);
               num_mneg = st_side[s].x_neg;
            end
            den_m   = pte_pkg::ONE_Q28;
            num_add = '0;
            den_add = '0;
         end
      end

      pte_mac u_mac (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (st_valid[s]),
         .in_side   (st_side[s]),
         .num_v     (st_num[s]),
         .den_v     (st_den[s]),
         .num_m     (num_m),
         .num_mneg  (num_mneg),
         .den_m     (den_m),
         .den_mneg  (1'b0),
         .num_add   (num_add),
         .den_add   (den_add),
         .out_valid (st_valid[s+1]),
         .out_side  (st_side[s+1]),
         .num_r     (st_num[s+1]),
         .den_r     (st_den[s+1])
      );
   end

   pte_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (st_valid[NS]),
      .in_kind   (st_side[NS].kind),
      .in_num    (st_num[NS]),
      .in_den    (st_den[NS]),
      .out_valid (d_valid),
      .out_value (d_value),
      .out_sat   (d_sat)
   );

   // Output register plus one skid beat; the pipeline holds while the skid is full.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_tready) begin
            skid_full_ff <= 1'b0;
         end
      end else if (d_valid) begin
         if (out_valid_ff && !rsp_tready) begin
            skid_full_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (rsp_tready) begin
            out_value_ff <= skid_value_ff;
            out_sat_ff   <= skid_sat_ff;
         end
      end else if (d_valid) begin
         if (out_valid_ff && !rsp_tready) begin
            skid_value_ff <= d_value;
            skid_sat_ff   <= d_sat;
         end else begin
            out_value_ff <= d_value;
            out_sat_ff   <= d_sat;
         end
      end
   end

   assign req_tready   = en;
   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_value_ff;
   assign rsp_tuser[0] = out_sat_ff;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_valid_ff)
      else $error("skid holds a beat while the output register is empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && !rsp_tready |=> skid_full_ff && $stable(skid_value_ff))
      else $error("skid beat lost during stall");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(out_valid_ff && !rsp_tready && d_valid))
      else $error("skid filled without a stalled result");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff && $stable(out_value_ff))
      else $error("waiting result changed during stall");
`endif

endmodule
